>>> sv/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg
// Shared types and constants of the vector normalize pipeline.
// ----------------------------------------------------------------------------
package v3n_pkg;

  localparam int LANES     = 3;
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = 32 / SQ_STEPS;
  localparam int DV_BITS   = 31;
  localparam int DV_STEPS  = 2;
  localparam int DV_STAGES = (DV_BITS + DV_STEPS - 1) / DV_STEPS;
  localparam int LATENCY   = 3 + SQ_STAGES + DV_STAGES + 1;

  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [31:0] EPSILON_RST = 32'd7;

  typedef struct packed {
    logic [LANES-1:0]       neg;
    logic [LANES-1:0][31:0] mag;
  } side_t;

endpackage

>>> sv/v3n_square.sv
// ----------------------------------------------------------------------------
// v3n_square
// Component magnitudes, squares and their exact 64-bit sum, three stages.
// ----------------------------------------------------------------------------
module v3n_square (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  logic [31:0]             vec_x,
  input  logic [31:0]             vec_y,
  input  logic [31:0]             vec_z,
  output logic                    out_vld,
  output logic [63:0]             sum,
  output v3n_pkg::side_t          side
);
  import v3n_pkg::*;

  logic [LANES-1:0][31:0] raw;
  side_t                  s1;
  side_t                  s2;
  logic [LANES-1:0][63:0] sq;
  logic [2:0]             vld;

  assign raw = {vec_z, vec_y, vec_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_vld};
    end
    for (int l = 0; l < LANES; l++) begin
      s1.neg[l] <= raw[l][31];
      s1.mag[l] <= raw[l][31] ? (~raw[l] + 32'd1) : raw[l];
      sq[l]     <= {32'd0, s1.mag[l]} * {32'd0, s1.mag[l]};
    end
    s2   <= s1;
    side <= s2;
    sum  <= sq[0] + sq[1] + sq[2];
  end

  assign out_vld = vld[2];

endmodule

>>> sv/v3n_sqrt.sv
// ----------------------------------------------------------------------------
// v3n_sqrt
// Pipelined integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module v3n_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_vld,
  input  logic [63:0]             sum,
  input  v3n_pkg::side_t          in_side,
  output logic                    out_vld,
  output logic [31:0]             root,
  output v3n_pkg::side_t          out_side
);
  import v3n_pkg::*;

  logic [SQ_STAGES-1:0] vld;
  logic [63:0]          val  [SQ_STAGES];
  logic [33:0]          rem  [SQ_STAGES];
  logic [31:0]          rt   [SQ_STAGES];
  side_t                side [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_st
    logic        v_in;
    logic [63:0] val_in;
    logic [33:0] rem_in;
    logic [31:0] rt_in;
    side_t       side_in;
    logic [33:0] rem_c;
    logic [31:0] rt_c;
    logic [35:0] sh;
    logic [35:0] trial;

    if (s == 0) begin : g_first
      assign v_in    = in_vld;
      assign val_in  = sum;
      assign rem_in  = '0;
      assign rt_in   = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld[s-1];
      assign val_in  = val[s-1];
      assign rem_in  = rem[s-1];
      assign rt_in   = rt[s-1];
      assign side_in = side[s-1];
    end

    always_comb begin
      rem_c = rem_in;
      rt_c  = rt_in;
      sh    = '0;
      trial = '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sh    = {rem_c, val_in[2*(31-(SQ_STEPS*s+k))+1 -: 2]};
        trial = {2'b00, rt_c, 2'b01};
        if (sh >= trial) begin
          rem_c = 34'(sh - trial);
          rt_c  = {rt_c[30:0], 1'b1};
        end else begin
          rem_c = sh[33:0];
          rt_c  = {rt_c[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= v_in;
      end
      val[s]  <= val_in;
      rem[s]  <= rem_c;
      rt[s]   <= rt_c;
      side[s] <= side_in;
    end
  end

  assign out_vld  = vld[SQ_STAGES-1];
  assign root     = rt[SQ_STAGES-1];
  assign out_side = side[SQ_STAGES-1];

endmodule

>>> sv/v3n_div.sv
// ----------------------------------------------------------------------------
// v3n_div
// Three-lane pipelined restoring divider, magnitude / length in Q2.30.
// ----------------------------------------------------------------------------
module v3n_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_vld,
  input  logic [31:0]                       len,
  input  v3n_pkg::side_t                    in_side,
  output logic                              out_vld,
  output logic [31:0]                       out_len,
  output logic [v3n_pkg::LANES-1:0]         out_neg,
  output logic [v3n_pkg::LANES-1:0]         out_sat,
  output logic [v3n_pkg::LANES-1:0][30:0]   quo
);
  import v3n_pkg::*;

  logic [DV_STAGES-1:0]   vld;
  logic [31:0]            ln  [DV_STAGES];
  logic [LANES-1:0]       neg [DV_STAGES];
  logic [LANES-1:0]       sat [DV_STAGES];
  logic [LANES-1:0][31:0] rem [DV_STAGES];
  logic [LANES-1:0][30:0] q   [DV_STAGES];

  for (genvar s = 0; s < DV_STAGES; s++) begin : g_st
    logic                   v_in;
    logic [31:0]            ln_in;
    logic [LANES-1:0]       neg_in;
    logic [LANES-1:0]       sat_in;
    logic [LANES-1:0]       lsb_in;
    logic [LANES-1:0][31:0] rem_in;
    logic [LANES-1:0][30:0] q_in;
    logic [LANES-1:0][31:0] rem_c;
    logic [LANES-1:0][30:0] q_c;
    logic [32:0]            sh;

    if (s == 0) begin : g_first
      assign v_in  = in_vld;
      assign ln_in = len;
      assign neg_in = in_side.neg;
      assign q_in  = '0;
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          sat_in[l] = in_side.mag[l] > len;
          lsb_in[l] = in_side.mag[l][0];
          rem_in[l] = {1'b0, in_side.mag[l][31:1]};
        end
      end
    end else begin : g_next
      assign v_in   = vld[s-1];
      assign ln_in  = ln[s-1];
      assign neg_in = neg[s-1];
      assign sat_in = sat[s-1];
      assign lsb_in = '0;
      assign rem_in = rem[s-1];
      assign q_in   = q[s-1];
    end

    always_comb begin
      rem_c = rem_in;
      q_c   = q_in;
      sh    = '0;
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < DV_STEPS; k++) begin
          if (DV_STEPS * s + k < DV_BITS) begin
            sh = {rem_c[l], (k == 0) ? lsb_in[l] : 1'b0};
            if (sh >= {1'b0, ln_in}) begin
              rem_c[l] = 32'(sh - {1'b0, ln_in});
              q_c[l]   = {q_c[l][29:0], 1'b1};
            end else begin
              rem_c[l] = sh[31:0];
              q_c[l]   = {q_c[l][29:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= v_in;
      end
      ln[s]  <= ln_in;
      neg[s] <= neg_in;
      sat[s] <= sat_in;
      rem[s] <= rem_c;
      q[s]   <= q_c;
    end
  end

  assign out_vld = vld[DV_STAGES-1];
  assign out_len = ln[DV_STAGES-1];
  assign out_neg = neg[DV_STAGES-1];
  assign out_sat = sat[DV_STAGES-1];
  assign quo     = q[DV_STAGES-1];

endmodule

>>> sv/vector3_normalize_core.sv
// ----------------------------------------------------------------------------
// vector3_normalize_core
// One request per cycle, sustained, while busy is low. Requests pass through the
// square stages, the 16-stage square root and the 16-stage divider, two bits per stage.
// busy is high only during reset; results cannot be stalled.
// Synchronous reset clears valid bits and sets epsilon to 7.
// ----------------------------------------------------------------------------
module vector3_normalize_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] vec_x,
  input  logic [31:0] vec_y,
  input  logic [31:0] vec_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] length,
  output logic [31:0] unit_x,
  output logic [31:0] unit_y,
  output logic [31:0] unit_z,
  output logic        degenerate
);
  import v3n_pkg::*;

  logic                   sq_vld;
  logic [63:0]            sq_sum;
  side_t                  sq_side;
  logic                   rt_vld;
  logic [31:0]            rt_root;
  side_t                  rt_side;
  logic                   dv_vld;
  logic [31:0]            dv_len;
  logic [LANES-1:0]       dv_neg;
  logic [LANES-1:0]       dv_sat;
  logic [LANES-1:0][30:0] dv_quo;
  logic [31:0]            epsilon;
  logic                   degen_c;
  logic [LANES-1:0][31:0] unit_c;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  v3n_square u_square (
    .clk(clk), .rst(rst), .in_vld(start & ~busy),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .out_vld(sq_vld), .sum(sq_sum), .side(sq_side)
  );

  v3n_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_vld(sq_vld), .sum(sq_sum), .in_side(sq_side),
    .out_vld(rt_vld), .root(rt_root), .out_side(rt_side)
  );

  v3n_div u_div (
    .clk(clk), .rst(rst), .in_vld(rt_vld), .len(rt_root), .in_side(rt_side),
    .out_vld(dv_vld), .out_len(dv_len), .out_neg(dv_neg), .out_sat(dv_sat),
    .quo(dv_quo)
  );

  always_comb begin
    degen_c = (dv_len == 32'd0) || (dv_len < epsilon);
    for (int l = 0; l < LANES; l++) begin
      unit_c[l] = dv_sat[l] ? ONE_Q30 : {1'b0, dv_quo[l]};
      if (dv_neg[l]) begin
        unit_c[l] = ~unit_c[l] + 32'd1;
      end
      if (degen_c) begin
        unit_c[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPSILON_RST;
      done    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        epsilon <= cfg_data;
      end
      done <= dv_vld;
    end
    length     <= dv_len;
    unit_x     <= unit_c[0];
    unit_y     <= unit_c[1];
    unit_z     <= unit_c[2];
    degenerate <= degen_c;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request did not complete after fixed latency");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (unit_x == 32'd0 && unit_y == 32'd0 && unit_z == 32'd0))
    else $error("degenerate result with nonzero unit vector");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |-> (length != 32'd0 && length >= epsilon))
    else $error("non-degenerate result below epsilon");

endmodule

>>> tb/sv/vector3_normalize_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_core_tb
// Drives Q16.16 vectors into the normalize core with random gaps and checks
// the length, the Q2.30 unit vector and the degenerate flag against an
// in-bench fixed-point model. The epsilon threshold is changed between phases.
// ----------------------------------------------------------------------------
module vector3_normalize_core_tb;
  import v3n_pkg::*;

  typedef struct packed {
    logic [31:0] len;
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic        degen;
  } norm_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          known;
    norm_t       res;
  } vec_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] vec_x = '0;
  logic [31:0] vec_y = '0;
  logic [31:0] vec_z = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [31:0] length;
  logic [31:0] unit_x;
  logic [31:0] unit_y;
  logic [31:0] unit_z;
  logic        degenerate;

  logic [31:0] eps_model;
  norm_t       norm_q[$];
  int          errors = 0;
  int          n_req = 0;
  int          n_res = 0;
  int          n_degen = 0;
  vec_row_t    rows[$];

  vector3_normalize_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .length(length), .unit_x(unit_x), .unit_y(unit_y),
    .unit_z(unit_z), .degenerate(degenerate)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag_of(logic [31:0] c);
    return c[31] ? 64'h1_0000_0000 - {32'd0, c} : {32'd0, c};
  endfunction

  function automatic logic [31:0] unit_lane(logic [31:0] c, logic [63:0] len);
    logic [63:0] q;
    q = (mag_of(c) << 30) / len;
    if (q > {32'd0, ONE_Q30}) q = {32'd0, ONE_Q30};
    return c[31] ? 32'd0 - q[31:0] : q[31:0];
  endfunction

  function automatic norm_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    norm_t       r;
    logic [63:0] sum;
    logic [63:0] len;
    sum = mag_of(x) * mag_of(x) + mag_of(y) * mag_of(y) + mag_of(z) * mag_of(z);
    len = sqrt_floor(sum);
    r.len = len[31:0];
    r.degen = (len == 0) || (len[31:0] < eps_model);
    r.ux = r.degen ? 32'd0 : unit_lane(x, len);
    r.uy = r.degen ? 32'd0 : unit_lane(y, len);
    r.uz = r.degen ? 32'd0 : unit_lane(z, len);
    return r;
  endfunction

  always @(posedge clk) begin
    norm_t e;
    if (!rst && done) begin
      n_res++;
      if (norm_q.size() == 0) begin
        $error("unexpected result length=%h", length);
        errors++;
      end else begin
        e = norm_q.pop_front();
        if (degenerate) n_degen++;
        if (length !== e.len) begin
          $error("length exp %h got %h", e.len, length); errors++;
        end
        if (unit_x !== e.ux) begin
          $error("unit_x exp %h got %h", e.ux, unit_x); errors++;
        end
        if (unit_y !== e.uy) begin
          $error("unit_y exp %h got %h", e.uy, unit_y); errors++;
        end
        if (unit_z !== e.uz) begin
          $error("unit_z exp %h got %h", e.uz, unit_z); errors++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate exp %b got %b", e.degen, degenerate); errors++;
        end
      end
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 15) - 8;
      2: return {{16{1'b0}}, 16'($urandom())} ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit known,
                          norm_t typed);
    int g;
    norm_t e;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    start <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    e = normalize(x, y, z);
    if (known && typed !== e) begin
      $error("table row disagrees with model: %h %h %h", x, y, z);
      errors++;
    end
    do @(posedge clk); while (busy);
    norm_q.push_back(e);
    n_req++;
  endtask

  task automatic set_epsilon(logic [31:0] v);
    start <= 1'b0;
    while (norm_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eps_model = v;
  endtask

  task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit known,
                         norm_t r);
    vec_row_t t;
    t.x = x; t.y = y; t.z = z; t.known = known; t.res = r;
    rows.push_back(t);
  endtask

  initial begin
    logic [31:0] eps_set[5];
    int mode;
    eps_model = EPSILON_RST;
    eps_set = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd7, $urandom()};
    // directed table; typed results where obvious
    add_row(0, 0, 0, 1, '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
    add_row(32'h0001_0000, 0, 0, 1, '{32'h0001_0000, ONE_Q30, 32'd0, 32'd0, 1'b0});
    add_row(0, 32'hFFFF_0000, 0, 1, '{32'h0001_0000, 32'd0, 32'hC000_0000, 32'd0, 1'b0});
    add_row(0, 0, 32'h8000_0000, 1, '{32'h8000_0000, 32'd0, 32'd0, 32'hC000_0000, 1'b0});
    add_row(32'h7FFF_FFFF, 0, 0, 1, '{32'h7FFF_FFFF, ONE_Q30, 32'd0, 32'd0, 1'b0});
    add_row(32'd6, 0, 0, 1, '{32'd6, 32'd0, 32'd0, 32'd0, 1'b1});
    add_row(32'd7, 0, 0, 1, '{32'd7, ONE_Q30, 32'd0, 32'd0, 1'b0});
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0);
    add_row(32'd3, 32'd4, 32'hFFFF_FFFF, 0, '0);
    add_row(32'h0003_0000, 32'hFFFC_0000, 32'd0, 0, '0);
    add_row(32'd5, 32'd5, 32'd5, 0, '0);
    add_row(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 0, '0);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 0, '0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_vec(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);
    foreach (eps_set[p]) begin
      set_epsilon(eps_set[p]);
      for (int k = 0; k < 150; k++) begin
        mode = $urandom_range(0, 4);
        send_vec(rand_comp(mode), rand_comp(mode), rand_comp(mode), 0, '0);
      end
    end
    start <= 1'b0;
    while (norm_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d vectors over 6 epsilon settings (zero and all-ones included).", n_req);
    $display("Checked %0d results, %0d of them degenerate.", n_res, n_degen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
sv/v3n_pkg.sv
sv/v3n_square.sv
sv/v3n_sqrt.sv
sv/v3n_div.sv
sv/vector3_normalize_core.sv
tb/sv/vector3_normalize_core_tb.sv
